FILE: sv/eaib_pkg.sv
// Shared constants and codes for the edge adjacency index builder.
package eaib_pkg;

   localparam int unsigned MAX_ENTITIES = 4096;
   localparam int unsigned MAX_EDGES    = 4096;

   localparam int unsigned ENT_W   = 16;
   localparam int unsigned CNT_W   = 13;
   localparam int unsigned EDGE_W  = 12;
   localparam int unsigned OP_W    = 3;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned REQ_W   = 64;
   localparam int unsigned RSP_W   = 40;

   localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
   localparam logic [OP_W-1:0] OP_BUILD    = 3'd1;
   localparam logic [OP_W-1:0] OP_OUT_RNG  = 3'd2;
   localparam logic [OP_W-1:0] OP_IN_RNG   = 3'd3;
   localparam logic [OP_W-1:0] OP_OUT_SLOT = 3'd4;
   localparam logic [OP_W-1:0] OP_IN_SLOT  = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd3;

endpackage

FILE: sv/edge_adjacency_index_builder_unit.sv
// Top level of the edge adjacency index builder.
// Appends and invalid and not-built requests pass from S_OUT to the result register; range
// queries first go through S_QRY_B, S_QRY_E and S_QRY_DONE, slot reads through S_SLOT and
// S_SLOT_DONE, and S_OUT holds while an earlier result still waits on rsp_tready. A build
// clears the offset memories entry by entry and forms the prefix sums in S_PFX_RD and
// S_PFX_WR, over n+1 entries with n the entity count capped at 4096, and walks the edge table
// twice, in a count pass and a scatter pass; each memory takes one read and one write per
// cycle. A new item is accepted while a finished result still waits.
module edge_adjacency_index_builder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // source_entity[15:0], target_entity[31:16], query_entity[47:32], list_slot[59:48]
   input  logic [eaib_pkg::REQ_W-1:0]    req_tdata,
   // operation[2:0]
   input  logic [eaib_pkg::OP_W-1:0]     req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // range_begin[12:0], range_count[25:13], edge_number[37:26]
   output logic [eaib_pkg::RSP_W-1:0]    rsp_tdata,
   // status[1:0]
   output logic [eaib_pkg::STAT_W-1:0]   rsp_tuser,
   input  logic                          csr_wr_en,
   input  logic [eaib_pkg::CNT_W-1:0]    csr_wr_data
);
   import eaib_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_CNT_RD, S_CNT_OFF, S_CNT_WR, S_PFX_RD, S_PFX_WR,
      S_SCT_RD, S_SCT_CUR, S_SCT_WR, S_QRY_B, S_QRY_E, S_QRY_DONE,
      S_SLOT, S_SLOT_DONE, S_OUT
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   ec_ff;
   logic [CNT_W-1:0]   held_ff;
   logic               built_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   out_acc_ff, in_acc_ff;
   logic [CNT_W-1:0]   s_addr_ff, t_addr_ff;
   logic               s_ok_ff, t_ok_ff;
   logic [OP_W-1:0]    op_ff;
   logic [ENT_W-1:0]   qry_ff;
   logic [EDGE_W-1:0]  slot_ff;
   logic [CNT_W-1:0]   beg_ff;
   logic [CNT_W-1:0]   res_beg_ff, res_cnt_ff;
   logic [EDGE_W-1:0]  res_edge_ff;
   logic [STAT_W-1:0]  res_stat_ff;
   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;
   logic [STAT_W-1:0]  rsp_user_ff;

   logic [CNT_W-1:0]   live_n;
   logic [ENT_W-1:0]   n_wide;
   logic               accept;
   logic [ENT_W-1:0]   req_src, req_tgt, req_qry;
   logic [EDGE_W-1:0]  req_slot;

   logic               edge_we;
   logic [EDGE_W-1:0]  edge_wa, edge_ra;
   logic [ENT_W-1:0]   src_rd, tgt_rd;
   logic               off_we;
   logic [CNT_W-1:0]   off_wa, off_ra, out_off_wd, in_off_wd, out_off_rd, in_off_rd;
   logic               out_cur_we, in_cur_we;
   logic [CNT_W-1:0]   out_cur_wa, in_cur_wa, out_cur_wd, in_cur_wd;
   logic [CNT_W-1:0]   out_cur_ra, in_cur_ra, out_cur_rd, in_cur_rd;
   logic               out_list_we, in_list_we;
   logic [EDGE_W-1:0]  out_list_wa, in_list_wa, list_ra, out_list_rd, in_list_rd;
   logic [CNT_W-1:0]   out_sum, in_sum, off_rd, off_end, total;

   assign live_n   = (ec_ff > CNT_W'(MAX_ENTITIES)) ? CNT_W'(MAX_ENTITIES) : ec_ff;
   assign n_wide   = ENT_W'(live_n);
   assign req_src  = req_tdata[15:0];
   assign req_tgt  = req_tdata[31:16];
   assign req_qry  = req_tdata[47:32];
   assign req_slot = req_tdata[59:48];
   assign req_tready = (state_ff == S_IDLE);
   assign accept   = req_tvalid && req_tready;
   assign out_sum  = out_acc_ff + out_off_rd;
   assign in_sum   = in_acc_ff + in_off_rd;
   assign off_rd   = (op_ff == OP_OUT_RNG) ? out_off_rd : in_off_rd;
   assign off_end  = off_rd;
   assign total    = (op_ff == OP_OUT_SLOT) ? out_off_rd : in_off_rd;

   always_comb begin
      edge_we     = 1'b0;
      edge_wa     = held_ff[EDGE_W-1:0];
      edge_ra     = idx_ff[EDGE_W-1:0];
      off_we      = 1'b0;
      off_wa      = idx_ff;
      off_ra      = idx_ff;
      out_off_wd  = '0;
      in_off_wd   = '0;
      out_cur_we  = 1'b0;
      in_cur_we   = 1'b0;
      out_cur_wa  = idx_ff;
      in_cur_wa   = idx_ff;
      out_cur_wd  = out_sum;
      in_cur_wd   = in_sum;
      out_cur_ra  = s_addr_ff;
      in_cur_ra   = t_addr_ff;
      out_list_we = 1'b0;
      in_list_we  = 1'b0;
      out_list_wa = out_cur_rd[EDGE_W-1:0];
      in_list_wa  = in_cur_rd[EDGE_W-1:0];
      list_ra     = slot_ff;
      case (state_ff)
         S_IDLE: begin
            edge_we = accept && (req_tuser == OP_APPEND) && (held_ff < CNT_W'(MAX_EDGES));
         end
         S_CLR: begin
            off_we = 1'b1;
         end
         S_CNT_OFF: begin
            off_ra = CNT_W'(src_rd) + 1'b1;
         end
         S_CNT_WR: begin
            off_ra = s_addr_ff;
         end
         S_PFX_WR: begin
            off_we     = 1'b1;
            out_off_wd = out_sum;
            in_off_wd  = in_sum;
            out_cur_we = 1'b1;
            in_cur_we  = 1'b1;
         end
         S_SCT_CUR: begin
            out_cur_ra = src_rd[CNT_W-1:0];
            in_cur_ra  = tgt_rd[CNT_W-1:0];
         end
         S_SCT_WR: begin
            out_list_we = s_ok_ff;
            in_list_we  = t_ok_ff;
            out_cur_we  = s_ok_ff;
            in_cur_we   = t_ok_ff;
            out_cur_wa  = s_addr_ff;
            in_cur_wa   = t_addr_ff;
            out_cur_wd  = out_cur_rd + 1'b1;
            in_cur_wd   = in_cur_rd + 1'b1;
         end
         S_QRY_B: begin
            off_ra = qry_ff[CNT_W-1:0];
         end
         S_QRY_E: begin
            off_ra = qry_ff[CNT_W-1:0] + 1'b1;
         end
         S_SLOT: begin
            off_ra = live_n;
         end
         default: begin
         end
      endcase
   end

   // count phase writes out and in offsets at separate addresses
   logic               out_off_we, in_off_we;
   logic [CNT_W-1:0]   out_off_wa, in_off_wa, out_off_ra, in_off_ra;
   logic [CNT_W-1:0]   out_off_wdata, in_off_wdata;

   always_comb begin
      out_off_we    = off_we;
      in_off_we     = off_we;
      out_off_wa    = off_wa;
      in_off_wa     = off_wa;
      out_off_ra    = off_ra;
      in_off_ra     = off_ra;
      out_off_wdata = out_off_wd;
      in_off_wdata  = in_off_wd;
      case (state_ff)
         S_CNT_OFF: begin
            in_off_ra = CNT_W'(tgt_rd) + 1'b1;
         end
         S_CNT_WR: begin
            out_off_we    = s_ok_ff;
            in_off_we     = t_ok_ff;
            out_off_wa    = s_addr_ff;
            in_off_wa     = t_addr_ff;
            out_off_wdata = out_off_rd + 1'b1;
            in_off_wdata  = in_off_rd + 1'b1;
            in_off_ra     = t_addr_ff;
         end
         default: begin
         end
      endcase
   end

   eaib_ram #(.WIDTH(ENT_W), .DEPTH(MAX_EDGES)) u_src (
      .clock, .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(req_src),
      .rd_addr(edge_ra), .rd_data(src_rd));
   eaib_ram #(.WIDTH(ENT_W), .DEPTH(MAX_EDGES)) u_tgt (
      .clock, .wr_en(edge_we), .wr_addr(edge_wa), .wr_data(req_tgt),
      .rd_addr(edge_ra), .rd_data(tgt_rd));
   eaib_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ENTITIES + 1)) u_out_off (
      .clock, .wr_en(out_off_we), .wr_addr(out_off_wa), .wr_data(out_off_wdata),
      .rd_addr(out_off_ra), .rd_data(out_off_rd));
   eaib_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ENTITIES + 1)) u_in_off (
      .clock, .wr_en(in_off_we), .wr_addr(in_off_wa), .wr_data(in_off_wdata),
      .rd_addr(in_off_ra), .rd_data(in_off_rd));
   eaib_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ENTITIES + 1)) u_out_cur (
      .clock, .wr_en(out_cur_we), .wr_addr(out_cur_wa), .wr_data(out_cur_wd),
      .rd_addr(out_cur_ra), .rd_data(out_cur_rd));
   eaib_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ENTITIES + 1)) u_in_cur (
      .clock, .wr_en(in_cur_we), .wr_addr(in_cur_wa), .wr_data(in_cur_wd),
      .rd_addr(in_cur_ra), .rd_data(in_cur_rd));
   eaib_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_out_list (
      .clock, .wr_en(out_list_we), .wr_addr(out_list_wa), .wr_data(idx_ff[EDGE_W-1:0]),
      .rd_addr(list_ra), .rd_data(out_list_rd));
   eaib_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_in_list (
      .clock, .wr_en(in_list_we), .wr_addr(in_list_wa), .wr_data(idx_ff[EDGE_W-1:0]),
      .rd_addr(list_ra), .rd_data(in_list_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ec_ff        <= CNT_W'(1);
         held_ff      <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ec_ff    <= csr_wr_data;
            built_ff <= 1'b0;
         end
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff       <= req_tuser;
                  qry_ff      <= req_qry;
                  slot_ff     <= req_slot;
                  idx_ff      <= '0;
                  out_acc_ff  <= '0;
                  in_acc_ff   <= '0;
                  res_beg_ff  <= '0;
                  res_cnt_ff  <= '0;
                  res_edge_ff <= '0;
                  res_stat_ff <= ST_EMPTY;
                  state_ff    <= S_OUT;
                  if (req_tuser == OP_APPEND) begin
                     if (held_ff < CNT_W'(MAX_EDGES)) begin
                        held_ff     <= held_ff + 1'b1;
                        built_ff    <= 1'b0;
                        res_stat_ff <= ST_OK;
                     end else begin
                        res_stat_ff <= ST_FULL;
                     end
                  end else if (req_tuser == OP_BUILD) begin
                     state_ff <= S_CLR;
                  end else if (req_tuser == OP_OUT_RNG || req_tuser == OP_IN_RNG ||
                               req_tuser == OP_OUT_SLOT || req_tuser == OP_IN_SLOT) begin
                     if (!built_ff) begin
                        res_stat_ff <= ST_NOT_BUILT;
                     end else if (req_tuser == OP_OUT_SLOT || req_tuser == OP_IN_SLOT) begin
                        state_ff <= S_SLOT;
                     end else if (req_qry < n_wide) begin
                        state_ff <= S_QRY_B;
                     end
                  end
               end
            end
            S_CLR: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == live_n) begin
                  idx_ff   <= '0;
                  state_ff <= S_CNT_RD;
               end
            end
            S_CNT_RD: begin
               if (idx_ff == held_ff) begin
                  idx_ff   <= '0;
                  state_ff <= S_PFX_RD;
               end else begin
                  state_ff <= S_CNT_OFF;
               end
            end
            S_CNT_OFF: begin
               s_addr_ff <= CNT_W'(src_rd) + 1'b1;
               t_addr_ff <= CNT_W'(tgt_rd) + 1'b1;
               s_ok_ff   <= src_rd < n_wide;
               t_ok_ff   <= tgt_rd < n_wide;
               state_ff  <= S_CNT_WR;
            end
            S_CNT_WR: begin
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_CNT_RD;
            end
            S_PFX_RD: begin
               if (idx_ff > live_n) begin
                  idx_ff   <= '0;
                  state_ff <= S_SCT_RD;
               end else begin
                  state_ff <= S_PFX_WR;
               end
            end
            S_PFX_WR: begin
               out_acc_ff <= out_sum;
               in_acc_ff  <= in_sum;
               idx_ff     <= idx_ff + 1'b1;
               state_ff   <= S_PFX_RD;
            end
            S_SCT_RD: begin
               if (idx_ff == held_ff) begin
                  built_ff    <= 1'b1;
                  res_stat_ff <= ST_OK;
                  state_ff    <= S_OUT;
               end else begin
                  state_ff <= S_SCT_CUR;
               end
            end
            S_SCT_CUR: begin
               s_addr_ff <= src_rd[CNT_W-1:0];
               t_addr_ff <= tgt_rd[CNT_W-1:0];
               s_ok_ff   <= src_rd < n_wide;
               t_ok_ff   <= tgt_rd < n_wide;
               state_ff  <= S_SCT_WR;
            end
            S_SCT_WR: begin
               idx_ff   <= idx_ff + 1'b1;
               state_ff <= S_SCT_RD;
            end
            S_QRY_B: begin
               state_ff <= S_QRY_E;
            end
            S_QRY_E: begin
               beg_ff   <= off_rd;
               state_ff <= S_QRY_DONE;
            end
            S_QRY_DONE: begin
               if (beg_ff < off_end) begin
                  res_beg_ff  <= beg_ff;
                  res_cnt_ff  <= off_end - beg_ff;
                  res_stat_ff <= ST_OK;
               end
               state_ff <= S_OUT;
            end
            S_SLOT: begin
               state_ff <= S_SLOT_DONE;
            end
            S_SLOT_DONE: begin
               if (CNT_W'(slot_ff) < total) begin
                  res_edge_ff <= (op_ff == OP_OUT_SLOT) ? out_list_rd : in_list_rd;
                  res_stat_ff <= ST_OK;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= RSP_W'({res_edge_ff, res_cnt_ff, res_beg_ff});
                  rsp_user_ff  <= res_stat_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule

FILE: sv/eaib_ram.sv
// Single-port-write, single-port-read memory with registered read data.
module eaib_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: sv/eaib_checker.sv
// Port-level checks for the edge adjacency index builder, bound to the top level.
module eaib_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [eaib_pkg::RSP_W-1:0]  rsp_tdata,
   input logic [eaib_pkg::STAT_W-1:0] rsp_tuser
);
   import eaib_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_fail_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata[25:13] == '0)
      else $error("failed item carries a count");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL || rsp_tuser == ST_NOT_BUILT) |-> rsp_tdata == '0)
      else $error("rejected item carries data");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:13] == '0 || rsp_tdata[37:26] == '0)
      else $error("range and slot fields both set");
endmodule

bind edge_adjacency_index_builder_unit eaib_checker u_eaib_checker (
   .clock(clock), .reset(reset), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser));

FILE: test/edge_adjacency_index_builder_unit_check.sv
`timescale 1ns / 1ps
// Channel monitor, adjacency index predictor and result checker for the index builder.
module edge_adjacency_index_builder_unit_check
   import eaib_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,
   input  logic [OP_W-1:0]    req_tuser,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [RSP_W-1:0]   rsp_tdata,
   input  logic [STAT_W-1:0]  rsp_tuser,
   input  logic               csr_wr_en,
   input  logic [CNT_W-1:0]   csr_wr_data,
   output int                 fail_count,
   output int                 pending,
   output int                 checked
);

   typedef struct packed {
      logic [CNT_W-1:0]  range_begin;
      logic [CNT_W-1:0]  range_count;
      logic [EDGE_W-1:0] edge_number;
      logic [STAT_W-1:0] status;
   } lookup_type;

   localparam int EXP_DEPTH = 16;

   lookup_type expected_lookups[EXP_DEPTH];
   int         exp_wr;
   int         exp_rd;

   int unsigned src_tab[MAX_EDGES];
   int unsigned dst_tab[MAX_EDGES];
   int unsigned out_start[MAX_ENTITIES+1];
   int unsigned in_start[MAX_ENTITIES+1];
   int unsigned out_next[MAX_ENTITIES+1];
   int unsigned in_next[MAX_ENTITIES+1];
   int unsigned out_edges[MAX_EDGES];
   int unsigned in_edges[MAX_EDGES];
   int unsigned held_edges;
   int unsigned entity_limit;
   bit          index_valid;

   assign pending = exp_wr - exp_rd;

   function automatic int unsigned live_count();
      return (entity_limit > MAX_ENTITIES) ? MAX_ENTITIES : entity_limit;
   endfunction

   function automatic void build_index();
      int unsigned n, e, v, s, t;
      n = live_count();
      for (v = 0; v <= MAX_ENTITIES; v++) begin
         out_start[v] = 0;
         in_start[v]  = 0;
      end
      for (e = 0; e < held_edges; e++) begin
         if (src_tab[e] < n) out_start[src_tab[e]+1]++;
         if (dst_tab[e] < n) in_start[dst_tab[e]+1]++;
      end
      for (v = 0; v < n; v++) begin
         out_start[v+1] += out_start[v];
         in_start[v+1]  += in_start[v];
      end
      out_next = out_start;
      in_next  = in_start;
      for (e = 0; e < held_edges; e++) begin
         s = src_tab[e];
         t = dst_tab[e];
         if (s < n && out_next[s] < MAX_EDGES) out_edges[out_next[s]++] = e;
         if (t < n && in_next[t] < MAX_EDGES) in_edges[in_next[t]++] = e;
      end
      index_valid = 1;
   endfunction

   function automatic lookup_type predict_lookup(logic [OP_W-1:0] op,
                                                 logic [REQ_W-1:0] fields);
      lookup_type  r;
      int unsigned n, q, b, e, slot, total;
      r = '0;
      r.status = ST_EMPTY;
      n = live_count();
      if (op == OP_APPEND) begin
         if (held_edges >= MAX_EDGES) begin
            r.status = ST_FULL;
         end else begin
            src_tab[held_edges] = fields[15:0];
            dst_tab[held_edges] = fields[31:16];
            held_edges++;
            index_valid = 0;
            r.status = ST_OK;
         end
      end else if (op == OP_BUILD) begin
         build_index();
         r.status = ST_OK;
      end else if (op <= OP_IN_SLOT) begin
         if (!index_valid) begin
            r.status = ST_NOT_BUILT;
         end else if (op == OP_OUT_RNG || op == OP_IN_RNG) begin
            q = fields[47:32];
            if (q < n) begin
               b = (op == OP_OUT_RNG) ? out_start[q] : in_start[q];
               e = (op == OP_OUT_RNG) ? out_start[q+1] : in_start[q+1];
               if (b < e && e <= MAX_EDGES) begin
                  r.range_begin = CNT_W'(b);
                  r.range_count = CNT_W'(e - b);
                  r.status = ST_OK;
               end
            end
         end else begin
            slot  = fields[59:48];
            total = (op == OP_OUT_SLOT) ? out_start[n] : in_start[n];
            if (slot < total) begin
               r.edge_number = EDGE_W'((op == OP_OUT_SLOT) ? out_edges[slot] : in_edges[slot]);
               r.status = ST_OK;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      lookup_type want, got;
      if (reset) begin
         held_edges   = 0;
         index_valid  = 0;
         entity_limit = 1;
         exp_wr       = 0;
         exp_rd       = 0;
         fail_count   = 0;
         checked      = 0;
      end else begin
         if (csr_wr_en) begin
            entity_limit = csr_wr_data;
            index_valid  = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.range_begin = rsp_tdata[12:0];
            got.range_count = rsp_tdata[25:13];
            got.edge_number = rsp_tdata[37:26];
            got.status      = rsp_tuser;
            checked++;
            if (exp_wr == exp_rd) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result begin=%0d count=%0d edge=%0d status=%0d",
                           $realtime, got.range_begin, got.range_count, got.edge_number,
                           got.status);
            end else begin
               want = expected_lookups[exp_rd % EXP_DEPTH];
               exp_rd++;
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: mismatch expected begin=%0d count=%0d edge=%0d ",
                               "status=%0d, got begin=%0d count=%0d edge=%0d status=%0d"},
                              $realtime, want.range_begin, want.range_count,
                              want.edge_number, want.status, got.range_begin,
                              got.range_count, got.edge_number, got.status);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_lookups[exp_wr % EXP_DEPTH] = predict_lookup(req_tuser, req_tdata);
            exp_wr++;
         end
      end
   end

endmodule

FILE: test/edge_adjacency_index_builder_unit_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the edge adjacency index builder.
module edge_adjacency_index_builder_unit_test;
   import eaib_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic [OP_W-1:0]    req_tuser = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic [STAT_W-1:0]  rsp_tuser;
   logic               csr_wr_en = 1'b0;
   logic [CNT_W-1:0]   csr_wr_data = '0;
   int                 fail_count, pending, checked;

   int unsigned burst_left = 0;
   int unsigned items_sent = 0;
   int unsigned builds_sent = 0;
   int unsigned appends_sent = 0;
   int unsigned entity_setting = 1;
   int unsigned stall_phase = 0;

   always #5 clock = ~clock;

   edge_adjacency_index_builder_unit dut (.*);

   edge_adjacency_index_builder_unit_check checker_i (.*);

   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 300) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 9) < 7);
         2: rsp_tready <= ($urandom_range(0, 9) < 2);
         default: rsp_tready <= (stall_phase[3:0] < 4'd11);
      endcase
   end

   task automatic send_item(logic [OP_W-1:0] op, logic [15:0] src, logic [15:0] dst,
                            logic [15:0] qry, logic [11:0] slot);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, slot, qry, dst, src};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (op == OP_BUILD) builds_sent++;
      if (op == OP_APPEND) appends_sent++;
   endtask

   task automatic set_entities(logic [CNT_W-1:0] value);
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      entity_setting = value;
   endtask

   function automatic logic [15:0] pick_entity();
      int unsigned live, roll;
      live = (entity_setting > MAX_ENTITIES) ? MAX_ENTITIES : entity_setting;
      roll = $urandom_range(0, 99);
      if (roll < 75 && live != 0) return 16'($urandom_range(0, live - 1));
      if (roll < 88) return 16'(live + $urandom_range(0, 2));
      return 16'($urandom);
   endfunction

   function automatic logic [11:0] pick_slot();
      if ($urandom_range(0, 9) < 8 && appends_sent != 0)
         return 12'($urandom_range(0,
                    (appends_sent > MAX_EDGES ? MAX_EDGES : appends_sent) - 1));
      return 12'($urandom);
   endfunction

   task automatic random_item();
      int unsigned roll;
      logic [OP_W-1:0] op;
      roll = $urandom_range(0, 99);
      if (roll < 30) op = OP_APPEND;
      else if (roll < 35) op = OP_BUILD;
      else if (roll < 48) op = OP_OUT_RNG;
      else if (roll < 61) op = OP_IN_RNG;
      else if (roll < 79) op = OP_OUT_SLOT;
      else if (roll < 97) op = OP_IN_SLOT;
      else op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      send_item(op, pick_entity(), pick_entity(), pick_entity(), pick_slot());
   endtask

   initial begin
      #300ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic [CNT_W-1:0] settings[10];
      settings = '{13'd5, 13'd0, 13'd4096, 13'd8191, 13'd1, 13'd37, 13'd2, 13'd64, 13'd300, 13'd9};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_OUT_RNG, 0, 0, 0, 0);
      send_item(OP_IN_RNG, 0, 0, 0, 0);
      send_item(OP_OUT_SLOT, 0, 0, 0, 0);
      send_item(OP_IN_SLOT, 0, 0, 0, 0);
      send_item(OP_SPARE_LO, 16'hffff, 16'hffff, 16'hffff, 12'hfff);
      send_item(OP_SPARE_HI, 0, 0, 0, 0);
      send_item(OP_APPEND, 0, 0, 0, 0);
      send_item(OP_APPEND, 16'hffff, 16'hffff, 16'hffff, 12'hfff);
      send_item(OP_APPEND, 0, 16'hffff, 0, 0);
      send_item(OP_APPEND, 1, 0, 0, 0);
      send_item(OP_OUT_RNG, 0, 0, 0, 0);
      send_item(OP_BUILD, 0, 0, 0, 0);
      send_item(OP_OUT_RNG, 0, 0, 0, 0);
      send_item(OP_IN_RNG, 0, 0, 0, 0);
      send_item(OP_OUT_RNG, 0, 0, 1, 0);
      send_item(OP_IN_RNG, 0, 0, 16'hffff, 0);
      send_item(OP_OUT_SLOT, 0, 0, 0, 0);
      send_item(OP_OUT_SLOT, 0, 0, 0, 2);
      send_item(OP_IN_SLOT, 0, 0, 0, 1);
      send_item(OP_IN_SLOT, 0, 0, 0, 12'hfff);
      send_item(OP_APPEND, 0, 1, 0, 0);
      send_item(OP_IN_SLOT, 0, 0, 0, 0);

      foreach (settings[i]) begin
         set_entities(settings[i]);
         send_item(OP_BUILD, 0, 0, 0, 0);
         repeat (180) random_item();
      end

      set_entities(13'd4096);
      send_item(OP_BUILD, 0, 0, 0, 0);
      repeat (60) send_item(OP_W'($urandom_range(OP_OUT_RNG, OP_IN_SLOT)), 0, 0,
                            pick_entity(), pick_slot());
      set_entities(13'd3);
      send_item(OP_BUILD, 0, 0, 0, 0);
      repeat (40) random_item();

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (50) @(posedge clock);
      $display("Sent %0d items (%0d appends, %0d builds), %0d results checked, %0d mismatches",
               items_sent, appends_sent, builds_sent, checked, fail_count);
      $display("Covered pre-build queries, out-of-range endpoints, entity counts 0 to 8191, spare opcodes");
      if (fail_count == 0 && checked == items_sent)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
